// ===== src/blkdir_pkg.sv =====
// Package for the block directory: request and response item types, status codes
// and the directory entry layout.
// No dependencies.
package blkdir_pkg;

	localparam logic [15:0] EMPTY_IDENT = 16'hFFFF;

	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_CREATED = 2'd1;
	localparam logic [1:0] ST_FAILED  = 2'd2;
	localparam logic [1:0] ST_WIPED   = 2'd3;

	localparam logic KIND_OPEN = 1'b0;
	localparam logic KIND_WIPE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] block_id;
		logic [15:0] block_bytes;
		logic        want_read;
		logic        want_write;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] data_offset;
	} rsp_t;

	typedef struct packed {
		logic [15:0] ident;
		logic [15:0] length;
		logic [15:0] offset;
	} entry_t;

endpackage

// ===== src/block_directory_open_alloc_top.sv =====
// Block directory with open-or-allocate: entry memory, scan sequencer and result register.
// Depends on blkdir_pkg for the item types, entry layout and status codes.
//
// Channel   Signals            Direction  Handshake
// request   start, req, busy   in         accepted at an edge with start high and busy low
// response  done, rsp          out        valid for the one cycle that done is high
//
// A wipe, or an open that fails its permission or identifier check, answers in the cycle
// after it is accepted. Any other open scans the directory memory one entry per cycle
// through its single read port up to a hit, or past the last used entry to a miss that
// allocates if the open may write and room is left. Busy is high only during a scan and
// low once its result shows. Reset clears the entry count and the free offset; the entry
// memory itself is not cleared. The receiver cannot stall results.
module block_directory_open_alloc_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int DATA_BYTES  = 65152
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  blkdir_pkg::req_t  req,
	output logic              busy,
	output logic              done,
	output blkdir_pkg::rsp_t  rsp
);
	import blkdir_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
	localparam logic [16:0] DATA_LIM = 17'(DATA_BYTES);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	entry_t mem [MAX_ENTRIES];

	logic             state_q;
	req_t             req_q;
	logic [CNT_W-1:0] used_q;
	logic [16:0]      next_off_q;
	logic [CNT_W-1:0] idx_q;
	logic             rvalid_s1;
	entry_t           rdata_s1;
	logic             done_q;
	rsp_t             rsp_q;

	logic        accept;
	logic        early_fail;
	logic        hit;
	logic        more;
	logic [16:0] end_off;
	logic        alloc_ok;
	logic        mem_we;
	logic        mem_re;
	entry_t      wr_entry;

	assign accept     = start && !busy;
	assign early_fail = (!req.want_read && !req.want_write) || (req.block_id == EMPTY_IDENT);
	assign hit        = rvalid_s1 && (rdata_s1.ident == req_q.block_id)
	                    && (rdata_s1.length == req_q.block_bytes);
	assign more       = idx_q < used_q;
	assign end_off    = next_off_q + {1'b0, req_q.block_bytes};
	assign alloc_ok   = req_q.want_write && (used_q < CNT_MAX) && !next_off_q[16]
	                    && (end_off <= DATA_LIM);
	assign mem_re     = (state_q == S_SCAN) && !hit && more;
	assign mem_we     = (state_q == S_SCAN) && !hit && !more && alloc_ok;

	always_comb begin
		wr_entry.ident  = req_q.block_id;
		wr_entry.length = req_q.block_bytes;
		wr_entry.offset = next_off_q[15:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[used_q[IDX_W-1:0]] <= wr_entry;
		end
		if (mem_re) begin
			rdata_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			next_off_q <= '0;
			idx_q      <= '0;
			rvalid_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_WIPE) begin
							used_q     <= '0;
							next_off_q <= '0;
							done_q     <= 1'b1;
						end else if (early_fail) begin
							done_q <= 1'b1;
						end else begin
							idx_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (more) begin
						idx_q     <= idx_q + 1'b1;
						rvalid_s1 <= 1'b1;
					end else begin
						if (alloc_ok) begin
							used_q     <= used_q + 1'b1;
							next_off_q <= end_off;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if ((state_q == S_IDLE) && accept) begin
			rsp_q.status      <= (req.kind == KIND_WIPE) ? ST_WIPED : ST_FAILED;
			rsp_q.data_offset <= '0;
		end else if ((state_q == S_SCAN) && hit) begin
			rsp_q.status      <= ST_FOUND;
			rsp_q.data_offset <= rdata_s1.offset;
		end else if ((state_q == S_SCAN) && !more) begin
			rsp_q.status      <= alloc_ok ? ST_CREATED : ST_FAILED;
			rsp_q.data_offset <= alloc_ok ? next_off_q[15:0] : 16'd0;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_MAX)
		else $error("entry count exceeds directory depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= used_q))
		else $error("scan index ran past the used entries");

	a_found_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FOUND) |-> $past(rvalid_s1))
		else $error("found result without a directory read");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_FAILED || rsp.status == ST_WIPED)) |->
		(rsp.data_offset == 16'd0))
		else $error("failed or wiped result carries an offset");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

endmodule
